FILE: sv/i2p_pkg.sv
// shared types, character codes and operator codes of the infix to postfix converter
package i2p_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
    logic       error_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_OPERAND,
    KIND_OPER,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_END
  } kind_e;

  typedef logic [2:0] op_code_t;

  localparam op_code_t OP_ADD  = 3'd0;
  localparam op_code_t OP_SUB  = 3'd1;
  localparam op_code_t OP_MUL  = 3'd2;
  localparam op_code_t OP_DIV  = 3'd3;
  localparam op_code_t OP_OPEN = 3'd4;

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TERM  = 8'h78;

  // classified item passed from front to back
  typedef struct packed {
    kind_e      kind;
    op_code_t   code;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    case (code)
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_OPEN: c = CH_OPEN;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/infix_to_postfix_converter.sv
// Infix to postfix converter, top level.
// The input channel (in_valid_i, in_stall_o, in_i) takes one infix character per transfer,
// or an end-of-expression marker. The output channel (out_valid_o, out_stall_i, out_o)
// gives the postfix characters; last_of_run marks the final result of an input item and
// error_flag marks every result of an item with an unmatched ')' or a stack overflow.
// A two entry queue decouples classification from the stack sequencer, so input transfers
// continue while results wait at the output register.
// The stack sits in a ram with registered read, so each pop that leaves entries behind
// passes through a fetch state that loads the next top of stack; a ')' that drops its '('
// above other entries likewise passes through a fetch state to refetch the top.
// Reset clears the queue, the stack count and all valid flags; the stack memory itself is
// not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its result, the sequencer halts on
// its next result, and the queue fills and then stalls the sender.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2p_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2p_pkg::out_item_t  out_o
);
  import i2p_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic          cmd_valid, cmd_pop;
  cmd_t          cmd;
  logic [CW-1:0] stack_count, open_count;

  i2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_o         (out_o),
    .out_stall_i   (out_stall_i),
    .stack_count_o (stack_count),
    .open_count_o  (open_count)
  );

  // stack never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_count <= CW'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  // open parentheses tracked are a subset of the stacked entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_count <= stack_count)
    else $error("open parenthesis count exceeds stack count");

  // queue pops only happen when it holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

FILE: sv/i2p_ram.sv
// generic single write port ram with registered read
module i2p_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/i2p_front.sv
// input side: character classification and a two entry command queue
module i2p_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2p_pkg::in_item_t in_i,
  output logic              cmd_valid_o,
  output i2p_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import i2p_pkg::*;

  cmd_t       cmd_in;
  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  always_comb begin
    cmd_in.ch   = in_i.char_in;
    cmd_in.code = OP_ADD;
    cmd_in.kind = KIND_OPERAND;
    if (in_i.end_of_expression) begin
      cmd_in.kind = KIND_END;
    end else begin
      case (in_i.char_in)
        CH_ADD: begin
          cmd_in.kind = KIND_OPER;
          cmd_in.code = OP_ADD;
        end
        CH_SUB: begin
          cmd_in.kind = KIND_OPER;
          cmd_in.code = OP_SUB;
        end
        CH_MUL: begin
          cmd_in.kind = KIND_OPER;
          cmd_in.code = OP_MUL;
        end
        CH_DIV: begin
          cmd_in.kind = KIND_OPER;
          cmd_in.code = OP_DIV;
        end
        CH_OPEN: begin
          cmd_in.kind = KIND_OPEN;
          cmd_in.code = OP_OPEN;
        end
        CH_CLOSE: begin
          cmd_in.kind = KIND_CLOSE;
        end
        default: begin
          cmd_in.kind = KIND_OPERAND;
        end
      endcase
    end
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  assign wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
  assign fill_d   = fill_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: sv/i2p_back.sv
// execution side: operator stack sequencer, one-result hold stage and output register
module i2p_back #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  i2p_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_valid_o,
  output i2p_pkg::out_item_t                out_o,
  input  logic                              out_stall_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  stack_count_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  open_count_o
);
  import i2p_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_START     = 7'b0000010,
    S_LOOP      = 7'b0000100,
    S_FETCH     = 7'b0001000,
    S_FINISH    = 7'b0010000,
    S_FETCH_END = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  cmd_t      cmd_q, cmd_d;
  logic      err_q, err_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] open_q, open_d;
  logic      prev_q, prev_d;
  op_code_t  top_q, top_d;
  logic      pend_v_q, pend_v_d;
  logic [7:0] pend_q, pend_d;
  logic      out_v_q, out_v_d;
  out_item_t out_q, out_d;

  logic      out_free, emit_ok, emit, flush_last, load_out;
  logic [7:0] emit_ch;
  logic      full, should_pop, qual_new;
  logic      ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  op_code_t  ram_rdata;
  logic [CW-1:0] below_top;

  i2p_ram #(
    .WIDTH ($bits(op_code_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_q.code),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !out_v_q || !out_stall_i;
  assign emit_ok   = !pend_v_q || out_free;
  assign full      = (count_q == CW'(STACK_DEPTH));
  assign below_top = count_q - CW'(2);
  assign ram_raddr = below_top[AW-1:0];
  assign ram_waddr = count_q[AW-1:0];

  // does the operator waiting at the queue head pop the current top
  assign qual_new = (count_q != '0) && (top_q != OP_OPEN) &&
                    ((cmd_i.code < OP_MUL) || (top_q >= OP_MUL));

  always_comb begin
    should_pop = 1'b0;
    if (count_q != '0) begin
      case (cmd_q.kind)
        KIND_END:   should_pop = 1'b1;
        KIND_OPER:  should_pop = (top_q != OP_OPEN) &&
                                 ((cmd_q.code < OP_MUL) || (top_q >= OP_MUL));
        KIND_CLOSE: should_pop = (top_q != OP_OPEN);
        default:    should_pop = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    err_d      = err_q;
    count_d    = count_q;
    open_d     = open_q;
    prev_d     = prev_q;
    top_d      = top_q;
    emit       = 1'b0;
    emit_ch    = CH_SPACE;
    flush_last = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    cmd_pop_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_START;
          // the error is known up front so every result of the item carries it
          case (cmd_i.kind)
            KIND_OPER:  err_d = full && !qual_new;
            KIND_OPEN:  err_d = full;
            KIND_CLOSE: err_d = (open_q == '0);
            default:    err_d = 1'b0;
          endcase
        end
      end
      S_START: begin
        case (cmd_q.kind)
          KIND_END: begin
            if (emit_ok) begin
              emit    = 1'b1;
              prev_d  = 1'b0;
              state_d = S_LOOP;
            end
          end
          KIND_OPERAND: begin
            if (emit_ok) begin
              emit    = 1'b1;
              emit_ch = cmd_q.ch;
              prev_d  = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            if (!prev_q) begin
              state_d = S_LOOP;
            end else if (emit_ok) begin
              emit    = 1'b1;
              prev_d  = 1'b0;
              state_d = S_LOOP;
            end
          end
        endcase
      end
      S_LOOP: begin
        if (!should_pop) begin
          state_d = S_FINISH;
        end else if (emit_ok) begin
          emit    = 1'b1;
          emit_ch = op_char(top_q);
          count_d = count_q - CW'(1);
          // only an end item pops a '(' here
          if (top_q == OP_OPEN) begin
            open_d = open_q - CW'(1);
          end
          if (count_q > CW'(1)) begin
            ram_re  = 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        top_d   = ram_rdata;
        state_d = S_LOOP;
      end
      S_FINISH: begin
        case (cmd_q.kind)
          KIND_END: begin
            if (emit_ok) begin
              emit    = 1'b1;
              emit_ch = CH_TERM;
              open_d  = '0;
              state_d = S_DONE;
            end
          end
          KIND_OPER, KIND_OPEN: begin
            if (!full) begin
              ram_we  = 1'b1;
              top_d   = cmd_q.code;
              count_d = count_q + CW'(1);
              if (cmd_q.kind == KIND_OPEN) begin
                open_d = open_q + CW'(1);
              end
              state_d = S_DONE;
            end else if (emit_ok) begin
              emit    = 1'b1;
              state_d = S_DONE;
            end
          end
          KIND_CLOSE: begin
            if (count_q != '0) begin
              // top is the matching '(' here: drop it
              count_d = count_q - CW'(1);
              open_d  = open_q - CW'(1);
              if (count_q > CW'(1)) begin
                ram_re  = 1'b1;
                state_d = S_FETCH_END;
              end else begin
                state_d = S_DONE;
              end
            end else if (emit_ok) begin
              emit    = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_FETCH_END: begin
        top_d   = ram_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          flush_last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // one result is held back until it is known whether another follows
  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    load_out = 1'b0;
    if (emit) begin
      load_out = pend_v_q;
      pend_v_d = 1'b1;
      pend_d   = emit_ch;
    end else if (flush_last) begin
      load_out = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q && out_stall_i;
    out_d   = out_q;
    if (load_out) begin
      out_v_d           = 1'b1;
      out_d.char_out    = pend_q;
      out_d.last_of_run = flush_last;
      out_d.error_flag  = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      open_q   <= '0;
      prev_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      open_q   <= open_d;
      prev_q   <= prev_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    err_q  <= err_d;
    top_q  <= top_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o   = out_v_q;
  assign out_o         = out_q;
  assign stack_count_o = count_q;
  assign open_count_o  = open_q;

endmodule

FILE: sim/postfix_checker.sv
// checker for the infix to postfix converter: predicts postfix output and compares transfers
module postfix_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  i2p_pkg::in_item_t  in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  i2p_pkg::out_item_t out_i,
  output int                 fail_count_o,
  output int                 expected_left_o
);
  import i2p_pkg::*;

  // operator stack of the prediction, holds the operator characters themselves
  logic [7:0]  op_stack [STACK_DEPTH];
  int unsigned op_depth = 0;
  bit          prev_operand = 1'b0;
  out_item_t   postfix_q [$];
  int          fails = 0;

  assign fail_count_o = fails;

  function automatic bit additive(input logic [7:0] c);
    return (c == CH_ADD) || (c == CH_SUB);
  endfunction

  task automatic predict_postfix(input in_item_t it);
    logic [7:0] emitted [$];
    logic [7:0] c;
    bit         err;
    out_item_t  r;
    err = 1'b0;
    if (it.end_of_expression) begin
      emitted.push_back(CH_SPACE);
      while (op_depth > 0) begin
        op_depth--;
        emitted.push_back(op_stack[op_depth]);
      end
      emitted.push_back(CH_TERM);
      prev_operand = 1'b0;
    end else begin
      c = it.char_in;
      case (c)
        CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_OPEN, CH_CLOSE: begin
          if (prev_operand) emitted.push_back(CH_SPACE);
          prev_operand = 1'b0;
          if (c == CH_CLOSE) begin
            while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN) begin
              op_depth--;
              emitted.push_back(op_stack[op_depth]);
            end
            // unmatched close: the stack is already emptied above
            if (op_depth > 0) op_depth--;
            else err = 1'b1;
          end else begin
            // equal or higher precedence on top gets popped, never past an open paren
            if (c != CH_OPEN) begin
              while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN &&
                     (additive(c) || !additive(op_stack[op_depth-1]))) begin
                op_depth--;
                emitted.push_back(op_stack[op_depth]);
              end
            end
            if (op_depth < STACK_DEPTH) begin
              op_stack[op_depth] = c;
              op_depth++;
            end else begin
              err = 1'b1;
            end
          end
        end
        default: begin
          emitted.push_back(c);
          prev_operand = 1'b1;
        end
      endcase
    end
    if (err) emitted.push_back(CH_SPACE);
    foreach (emitted[i]) begin
      r.char_out    = emitted[i];
      r.last_of_run = (i == emitted.size() - 1);
      r.error_flag  = err;
      postfix_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      op_depth = 0;
      prev_operand = 1'b0;
      postfix_q.delete();
      expected_left_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_postfix(in_i);
      if (out_valid_i && !out_stall_i) begin
        if (postfix_q.size() == 0) begin
          fails++;
          // keep the log bounded when everything goes out of step
          if (fails < 50) $error("result with none pending: char_out %h", out_i.char_out);
        end else begin
          want = postfix_q.pop_front();
          if (out_i.char_out !== want.char_out) begin
            fails++;
            if (fails < 50)
              $error("char_out: expected %h, got %h", want.char_out, out_i.char_out);
          end
          if (out_i.last_of_run !== want.last_of_run) begin
            fails++;
            if (fails < 50)
              $error("last_of_run: expected %b, got %b", want.last_of_run, out_i.last_of_run);
          end
          if (out_i.error_flag !== want.error_flag) begin
            fails++;
            if (fails < 50)
              $error("error_flag: expected %b, got %b", want.error_flag, out_i.error_flag);
          end
        end
      end
      expected_left_o <= postfix_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
// testbench top of the infix to postfix converter: clock, reset, stimulus and verdict
module tb;
  import i2p_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        expected_left;

  int tx_max_gap = 17;
  int rx_max_gap = 17;
  bit hold_output = 1'b0;
  int sent = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  postfix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_i            (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_i           (out_item),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  // output side: random stall per result, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      n = $urandom_range(0, rx_max_gap);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eoe);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{char_in: c, end_of_expression: eoe};
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic send_end();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_operand_run();
    logic [7:0] c;
    repeat ($urandom_range(1, 2)) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
             c == CH_OPEN || c == CH_CLOSE);
      send_char(c, 1'b0);
    end
  endtask

  // well-formed expression with random operands, sometimes nested past the stack depth
  task automatic send_expression();
    int nest;
    nest = 0;
    if ($urandom_range(0, 7) == 0) begin
      nest = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      repeat (nest) send_char(CH_OPEN, 1'b0);
    end
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 3) == 0 && nest < 6) begin
        send_char(CH_OPEN, 1'b0);
        nest++;
      end
      send_operand_run();
      if (nest > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CH_CLOSE, 1'b0);
        nest--;
      end
      case ($urandom_range(0, 3))
        0: send_char(CH_ADD, 1'b0);
        1: send_char(CH_SUB, 1'b0);
        2: send_char(CH_MUL, 1'b0);
        default: send_char(CH_DIV, 1'b0);
      endcase
    end
    send_operand_run();
    repeat (nest) send_char(CH_CLOSE, 1'b0);
    send_end();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_left != 0);
  endtask

  initial begin
    int random_start;
    int phase;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // precedence, parens, unmatched close, open left at end, byte extremes
    send_str("a+b*c-(d/e)");
    send_end();
    send_str("a+)");
    send_str(")");
    send_str("(");
    send_end();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TERM, 1'b0);
    send_end();
    wait_drained();

    random_start = sent;
    phase = 0;
    // the long output hold-off in phase 4 always runs
    while (sent - random_start < RANDOM_ITEMS || phase <= 4) begin
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
      if (phase == 4) begin
        // output held off while input keeps coming: queue fills, input stalls
        hold_output = 1'b1;
        tx_max_gap = 0;
        send_expression();
        send_expression();
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        send_expression();
      end
      if (phase % 7 == 6) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
